[rtl/assert_macros.svh]
// Assertion macros used by the frame parser top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/sofp_pkg.sv]
// Package: types and constants of the frame parser.
package sofp_pkg;

  localparam int MAX_PAYLOAD_DEF = 255;
  localparam logic [7:0] START_BYTE_RST = 8'hAA;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_START_BYTE = 1'b0;

  localparam logic OP_FEED = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef logic [7:0] byte_t;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_PAY  = 2'd2,
    PH_SUM  = 2'd3
  } phase_t;

endpackage

[rtl/sofp_stream_if.sv]
// Interfaces: input item channel and result channel of the frame parser.
interface sofp_stream_if;
  logic             valid;
  logic             ready;
  logic             operation;
  sofp_pkg::byte_t  data_byte;
  sofp_pkg::byte_t  read_index;

  modport source (output valid, operation, data_byte, read_index, input ready);
  modport sink (input valid, operation, data_byte, read_index, output ready);
endinterface

interface sofp_result_if;
  logic             valid;
  logic             ready;
  logic             frame_good;
  logic             checksum_error;
  sofp_pkg::byte_t  frame_length;
  sofp_pkg::byte_t  error_count;
  sofp_pkg::byte_t  read_data;
  logic [1:0]       parser_phase;

  modport source (output valid, frame_good, checksum_error, frame_length, error_count,
                  read_data, parser_phase, input ready);
  modport sink (input valid, frame_good, checksum_error, frame_length, error_count,
                read_data, parser_phase, output ready);
endinterface

[rtl/sof_length_checksum_frame_parser.sv]
// Frame parser top level: parser state, payload memory, result pipeline.
// An accepted transaction is registered in the read stage, then in the output register.
// Throughput: one transaction per cycle while the result is not stalled; the payload memory does one write or one read.
// A stalled result is held in the output register while one more transaction is buffered.
// Reset (rst, synchronous): parser hunts, counters and sums clear, start byte is 0xAA.
// Payload entries read as zero until written; per-entry valid bits clear at reset.
`include "assert_macros.svh"

module sof_length_checksum_frame_parser #(
  parameter int MAX_PAYLOAD = sofp_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  sofp_stream_if.sink                   stream,
  sofp_result_if.source                 result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sofp_pkg::PADDR_W-1:0]  paddr,
  input  logic [sofp_pkg::PDATA_W-1:0]  pwdata,
  output logic [sofp_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [7:0] MAX_B = 8'(MAX_PAYLOAD);

  sofp_pkg::byte_t  start_byte;
  sofp_pkg::phase_t phase, phase_next;
  sofp_pkg::byte_t  length_reg, length_reg_next;
  sofp_pkg::byte_t  received_count, received_count_next;
  sofp_pkg::byte_t  running_sum, running_sum_next;
  sofp_pkg::byte_t  error_counter, error_counter_next;
  logic             good_next, bad_next, wr_en;

  sofp_pkg::byte_t  payload_mem [MAX_PAYLOAD];
  logic [MAX_PAYLOAD-1:0] payload_vld;
  sofp_pkg::byte_t  mem_q;

  logic             p1_valid, p1_is_read, p1_hit, p1_good, p1_bad;
  sofp_pkg::byte_t  p1_length, p1_err;
  sofp_pkg::phase_t p1_phase;

  logic             accept, is_feed, advance, rd_in_range;
  logic [AW-1:0]    wr_addr, rd_addr;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == sofp_pkg::REG_START_BYTE) ?
                  sofp_pkg::PDATA_W'(start_byte) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= sofp_pkg::START_BYTE_RST;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == sofp_pkg::REG_START_BYTE) begin
      start_byte <= pwdata[7:0];
    end
  end

  // Handshake
  assign advance      = p1_valid && (!result.valid || result.ready);
  assign stream.ready = !p1_valid || advance;
  assign accept       = stream.valid && stream.ready;
  assign is_feed      = stream.operation == sofp_pkg::OP_FEED;
  assign rd_in_range  = stream.read_index < MAX_B;
  assign wr_addr      = received_count[AW-1:0];
  assign rd_addr      = stream.read_index[AW-1:0];

  // Parser next state
  always_comb begin
    phase_next          = phase;
    length_reg_next     = length_reg;
    received_count_next = received_count;
    running_sum_next    = running_sum;
    error_counter_next  = error_counter;
    good_next           = 1'b0;
    bad_next            = 1'b0;
    wr_en               = 1'b0;
    if (accept && is_feed) begin
      unique case (phase)
        sofp_pkg::PH_HUNT: begin
          if (stream.data_byte == start_byte) begin
            running_sum_next = stream.data_byte;
            phase_next       = sofp_pkg::PH_LEN;
          end
        end
        sofp_pkg::PH_LEN: begin
          length_reg_next     = stream.data_byte;
          received_count_next = '0;
          running_sum_next    = 8'(running_sum + stream.data_byte);
          phase_next          = (stream.data_byte == 8'd0) ? sofp_pkg::PH_SUM
                                                           : sofp_pkg::PH_PAY;
        end
        sofp_pkg::PH_PAY: begin
          wr_en               = received_count < MAX_B;
          received_count_next = 8'(received_count + 8'd1);
          running_sum_next    = 8'(running_sum + stream.data_byte);
          phase_next          = (received_count_next == length_reg) ? sofp_pkg::PH_SUM
                                                                    : sofp_pkg::PH_PAY;
        end
        sofp_pkg::PH_SUM: begin
          if (running_sum == stream.data_byte) begin
            good_next = 1'b1;
          end else begin
            bad_next           = 1'b1;
            error_counter_next = 8'(error_counter + 8'd1);
          end
          phase_next = sofp_pkg::PH_HUNT;
        end
        default: phase_next = sofp_pkg::PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= sofp_pkg::PH_HUNT;
      length_reg     <= '0;
      received_count <= '0;
      running_sum    <= '0;
      error_counter  <= '0;
    end else begin
      phase          <= phase_next;
      length_reg     <= length_reg_next;
      received_count <= received_count_next;
      running_sum    <= running_sum_next;
      error_counter  <= error_counter_next;
    end
  end

  // Payload memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      payload_mem[wr_addr] <= stream.data_byte;
    end
    if (accept && !is_feed) begin
      mem_q <= payload_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_vld <= '0;
    end else if (wr_en) begin
      payload_vld[wr_addr] <= 1'b1;
    end
  end

  // Read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (accept) begin
      p1_valid <= 1'b1;
    end else if (advance) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_is_read <= !is_feed;
      p1_hit     <= rd_in_range && payload_vld[rd_addr];
      p1_good    <= good_next;
      p1_bad     <= bad_next;
      p1_length  <= length_reg_next;
      p1_err     <= error_counter_next;
      p1_phase   <= phase_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.frame_good     <= p1_good;
      result.checksum_error <= p1_bad;
      result.frame_length   <= p1_length;
      result.error_count    <= p1_err;
      result.read_data      <= (p1_is_read && p1_hit) ? mem_q : 8'd0;
      result.parser_phase   <= p1_phase;
    end
  end

  `ASSERT_NOW(a_flags_excl, p1_valid, !(p1_good && p1_bad), "good and error both set")
  `ASSERT_NOW(a_read_no_flags, p1_valid && p1_is_read, !p1_good && !p1_bad,
              "read transaction carries a checksum flag")
  `ASSERT_NOW(a_flag_hunts, p1_valid && (p1_good || p1_bad), p1_phase == sofp_pkg::PH_HUNT,
              "checksum byte did not return parser to hunt")
  `ASSERT_NEXT(a_err_incr, accept && is_feed && phase == sofp_pkg::PH_SUM
               && running_sum != stream.data_byte,
               error_counter == 8'($past(error_counter) + 8'd1),
               "error counter did not advance on mismatch")

endmodule
